FILE: src/hidx_pkg.sv
// ----------------------------------------------------------------------------
// hidx_pkg
// Shared types, constants and node decode for the curve index to point block.
// ----------------------------------------------------------------------------
package hidx_pkg;

  localparam int COORD_W = 18;
  localparam int INDEX_W = 64;

  // Configuration register indexes
  localparam logic REG_DIMS   = 1'b0;
  localparam logic REG_LEVELS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic single;
    logic last_level;
    logic last_axis;
  } status_t;

  // Sub-cube node: direction and inversion signs (1 = negative), swap axis
  typedef struct packed {
    logic [3:0] u_neg;
    logic [3:0] v_neg;
    logic [1:0] l;
  } node_t;

  // Largest level count so that dims*levels stays within the 64-bit index
  function automatic logic [6:0] level_cap(input logic [2:0] n);
    logic [6:0] r;
    case (n)
      3'd2:    r = 7'd32;
      3'd3:    r = 7'd21;
      3'd4:    r = 7'd16;
      default: r = 7'd64;
    endcase
    return r;
  endfunction

  // Node of one digit s among n axes (n = 2..4, s already masked to n bits)
  function automatic node_t node_of_digit(input logic [3:0] s, input logic [2:0] n);
    node_t      r;
    logic [4:0] top;
    logic [4:0] half;
    logic [4:0] rem;
    logic       prev_neg;
    logic       cur_neg;
    logic       q_neg;
    logic [1:0] last_ax;
    r        = '0;
    top      = (5'd1 << n) - 5'd1;
    last_ax  = 2'(n - 3'd1);
    half     = 5'd1 << n;
    rem      = {1'b0, s};
    prev_neg = 1'b1;
    cur_neg  = 1'b1;
    q_neg    = 1'b0;
    if (s == 4'd0) begin
      r.l = last_ax;
      for (int i = 0; i < 4; i++) begin
        if (i < int'(n)) begin
          r.u_neg[i] = 1'b1;
          r.v_neg[i] = 1'b1;
        end
      end
    end else if ({1'b0, s} == top) begin
      r.l = last_ax;
      for (int i = 0; i < 4; i++) begin
        if (i < int'(n)) begin
          r.u_neg[i] = 1'b1;
          r.v_neg[i] = 1'b1;
        end
      end
      r.u_neg[0]       = 1'b0;
      r.v_neg[0]       = 1'b0;
      r.v_neg[last_ax] = 1'b0;
    end else begin
      // walk the digit from its top bit, tracking direction changes
      for (int i = 0; i < 4; i++) begin
        if (i < int'(n)) begin
          half = half >> 1;
          if (rem >= half) begin
            if (rem == half && rem != 5'd1) begin
              r.l   = 2'(i);
              q_neg = 1'b1;
            end
            rem     = rem - half;
            cur_neg = 1'b0;
          end else begin
            cur_neg = 1'b1;
            if (rem == half - 5'd1 && rem != 5'd0) begin
              r.l   = 2'(i);
              q_neg = 1'b0;
            end
          end
          r.u_neg[i] = (prev_neg == cur_neg);
          r.v_neg[i] = r.u_neg[i];
          prev_neg   = cur_neg;
        end
      end
      r.v_neg[r.l]     = r.v_neg[r.l] ^ q_neg;
      r.v_neg[last_ax] = ~r.v_neg[last_ax];
    end
    return r;
  endfunction

endpackage

FILE: src/hilbert_index_to_point.sv
// ----------------------------------------------------------------------------
// hilbert_index_to_point
// Curve index to cube point, one coordinate per result transaction.
// ----------------------------------------------------------------------------
//  channel  | ports                        | handshake
//  ---------+------------------------------+---------------------------------
//  input    | index, at_end                | start high while busy low
//  result   | axis, coord, last            | valid strobe, one cycle each
//  config   | cfg_idx, cfg_data            | cfg_we, taken at once
//
// An item is loaded, then refined one level per cycle through the node
// decode and accumulators (one dimension is finished at load and skips
// the refinement), then emitted in emit cycles of one axis each. Results
// show in the cycle after their emit cycle and follow each other without gaps.
// Reset restores dims = 2 and levels = 10 and returns to idle.
// The receiver cannot stall; busy drops once the last axis has been emitted.
// ----------------------------------------------------------------------------
module hilbert_index_to_point import hidx_pkg::*; #(
  parameter int MAX_DIMS   = 4,
  parameter int MAX_LEVELS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [INDEX_W-1:0]        index,
  input  logic                      at_end,
  output logic                      valid,
  output logic [1:0]                axis,
  output logic signed [COORD_W-1:0] coord,
  output logic                      last,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [4:0]                cfg_data
);

  logic [2:0] dims;
  logic [4:0] levels;
  cmd_t       cmd;
  status_t    status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dims   <= 3'd2;
      levels <= 5'd10;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DIMS:   dims   <= cfg_data[2:0];
        REG_LEVELS: levels <= cfg_data;
        default:    ;
      endcase
    end
  end

  hidx_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  hidx_datapath #(
    .MAX_DIMS   (MAX_DIMS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_dims   (dims),
    .cfg_levels (levels),
    .index      (index),
    .at_end     (at_end),
    .valid      (valid),
    .axis       (axis),
    .coord      (coord),
    .last       (last)
  );

  // An accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // A point's last result is never directly followed by another result
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (valid && last) |=> !valid)
    else $error("result follows the last axis of a point");

  // Axes of one point come back to back in order
  a_axis_seq: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |=> (valid && axis == $past(axis) + 2'd1))
    else $error("axis sequence broken");

  // Only axis 0 may open a point
  a_axis_first: assert property (@(posedge clk) disable iff (rst)
    (valid && axis != 2'd0) |-> $past(valid))
    else $error("point opened on a nonzero axis");

  // More axes pending means the block is still busy
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |-> busy)
    else $error("idle while axes are pending");

endmodule

FILE: src/hidx_ctrl.sv
// ----------------------------------------------------------------------------
// hidx_ctrl
// Sequencer: load, one refinement level per cycle, then one axis per cycle.
// ----------------------------------------------------------------------------
module hidx_ctrl import hidx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        // one dimension: the point is ready right after the load
        if (status.single) begin
          state_next = ST_EMIT;
        end else begin
          cmd.step = 1'b1;
          if (status.last_level) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.last_axis) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: src/hidx_datapath.sv
// ----------------------------------------------------------------------------
// hidx_datapath
// Digit extraction, node decode, sign tracking and coordinate accumulators.
// ----------------------------------------------------------------------------
module hidx_datapath import hidx_pkg::*; #(
  parameter int MAX_DIMS   = 4,
  parameter int MAX_LEVELS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic [2:0]                cfg_dims,
  input  logic [4:0]                cfg_levels,
  input  logic [INDEX_W-1:0]        index,
  input  logic                      at_end,
  output logic                      valid,
  output logic [1:0]                axis,
  output logic signed [COORD_W-1:0] coord,
  output logic                      last
);

  localparam int ACC_W    = MAX_LEVELS + 2;
  localparam int LVL_W    = $clog2(MAX_LEVELS + 1);
  localparam int DIMS_CAP = (MAX_DIMS < 4) ? MAX_DIMS : 4;

  // Held transaction context
  logic [INDEX_W-1:0]      idx_r;
  logic                    end_r;
  logic [2:0]              n_r;
  logic [LVL_W-1:0]        m_r;
  logic [6:0]              pos_r;
  logic [ACC_W-1:0]        wt_r;
  logic signed [ACC_W-1:0] y_r [4];
  logic [3:0]              w_neg_r;
  logic [1:0]              it_r;
  logic [LVL_W-1:0]        lvl_r;
  logic [1:0]              axis_r;

  // Effective dimensions and levels from the registers
  logic [2:0]              n_eff;
  logic [6:0]              lv_ext;
  logic [6:0]              m_clamp;
  logic [6:0]              m_eff;
  logic [9:0]              total;
  logic [ACC_W-1:0]        full;
  logic [ACC_W-1:0]        xs;
  logic signed [ACC_W-1:0] y_single;

  always_comb begin
    if (cfg_dims == 3'd0) begin
      n_eff = 3'd1;
    end else if (cfg_dims > 3'(DIMS_CAP)) begin
      n_eff = 3'(DIMS_CAP);
    end else begin
      n_eff = cfg_dims;
    end
    lv_ext = {2'b00, cfg_levels};
    if (lv_ext < 7'd2) begin
      m_clamp = 7'd2;
    end else if (lv_ext > 7'(MAX_LEVELS)) begin
      m_clamp = 7'(MAX_LEVELS);
    end else begin
      m_clamp = lv_ext;
    end
    m_eff = (m_clamp > level_cap(n_eff)) ? level_cap(n_eff) : m_clamp;
    total = 10'(n_eff) * 10'(m_eff);
  end

  // One dimension: y = 2*x - 2^m directly
  assign full     = ACC_W'(1) << m_eff;
  assign xs       = index[ACC_W-1:0] & (full - ACC_W'(1));
  assign y_single = at_end ? $signed(full) : $signed((xs << 1) - full);

  // Digit of the current level
  logic [INDEX_W-1:0] shifted;
  logic [3:0]         dmask;
  logic [3:0]         digit;

  assign shifted = idx_r >> pos_r;
  assign dmask   = 4'((5'd1 << n_r) - 5'd1);
  assign digit   = end_r ? dmask : (shifted[3:0] & dmask);

  // Node decode, axis swap and sign update for one level
  node_t                   nd;
  logic [3:0]              u_sw;
  logic [3:0]              v_sw;
  logic [1:0]              l_adj;
  logic [3:0]              w_next;
  logic signed [ACC_W-1:0] y_step [4];

  always_comb begin
    nd         = node_of_digit(digit, n_r);
    u_sw       = nd.u_neg;
    v_sw       = nd.v_neg;
    u_sw[0]    = nd.u_neg[it_r];
    u_sw[it_r] = nd.u_neg[0];
    v_sw[0]    = nd.v_neg[it_r];
    v_sw[it_r] = nd.v_neg[0];
    if (nd.l == 2'd0) begin
      l_adj = it_r;
    end else if (nd.l == it_r) begin
      l_adj = 2'd0;
    end else begin
      l_adj = nd.l;
    end
    for (int i = 0; i < 4; i++) begin
      w_next[i] = w_neg_r[i] ^ ~v_sw[i];
      y_step[i] = (u_sw[i] ^ w_neg_r[i]) ? (y_r[i] - $signed(wt_r))
                                         : (y_r[i] + $signed(wt_r));
    end
  end

  // Context and accumulator registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r   <= index;
      end_r   <= at_end;
      n_r     <= n_eff;
      m_r     <= LVL_W'(m_eff);
      pos_r   <= 7'(total - 10'(n_eff));
      wt_r    <= ACC_W'(1) << (m_eff - 7'd1);
      w_neg_r <= '0;
      it_r    <= 2'd0;
      lvl_r   <= '0;
      axis_r  <= 2'd0;
      // one dimension is finished at load time
      for (int i = 0; i < 4; i++) begin
        if (i == 0 && n_eff == 3'd1) begin
          y_r[i] <= y_single;
        end else begin
          y_r[i] <= '0;
        end
      end
    end else if (cmd.step) begin
      pos_r   <= pos_r - 7'(n_r);
      wt_r    <= wt_r >> 1;
      w_neg_r <= w_next;
      it_r    <= l_adj;
      lvl_r   <= lvl_r + LVL_W'(1);
      for (int i = 0; i < 4; i++) begin
        y_r[i] <= y_step[i];
      end
    end else if (cmd.emit) begin
      axis_r <= axis_r + 2'd1;
    end
  end

  // Status to the controller
  assign status.single     = (n_r == 3'd1);
  assign status.last_level = (lvl_r == m_r - LVL_W'(1));
  assign status.last_axis  = (axis_r == 2'(n_r - 3'd1));

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      axis  <= axis_r;
      coord <= COORD_W'(y_r[axis_r]);
      last  <= status.last_axis;
    end
  end

endmodule

FILE: tb/sv/hilbert_index_to_point_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_index_to_point_test
// Self-checking bench for the curve index to cube point block. A local
// predictor walks the evolvent level by level for every accepted index and
// queues one expected coordinate per axis. A monitor compares each result
// strobe against that queue. Directed cases cover the node corners and the
// register clamps, then random points run under several input idle patterns.
// ----------------------------------------------------------------------------
module hilbert_index_to_point_test import hidx_pkg::*;;

  localparam int DIMS_CAP      = 4;
  localparam int LEVELS_CAP    = 16;
  localparam int SETTLE_CYCLES = 4;
  localparam int BLOCK_ITEMS   = 20;
  localparam int RAND_BLOCKS   = 6;

  // one expected coordinate transaction
  typedef struct packed {
    logic [1:0]                axis;
    logic signed [COORD_W-1:0] coord;
    logic                      last;
  } coord_rec_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [INDEX_W-1:0]        index;
  logic                      at_end;
  logic                      valid;
  logic [1:0]                axis;
  logic signed [COORD_W-1:0] coord;
  logic                      last;
  logic                      cfg_we;
  logic                      cfg_idx;
  logic [4:0]                cfg_data;

  // register shadow, as written
  logic [2:0] dims_reg;
  logic [4:0] levels_reg;

  coord_rec_t pending_coords[$];
  int         errors       = 0;
  int         points_sent  = 0;
  int         end_points   = 0;
  int         coords_seen  = 0;
  int         settings_cnt = 0;

  hilbert_index_to_point #(
    .MAX_DIMS  (DIMS_CAP),
    .MAX_LEVELS(LEVELS_CAP)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .index   (index),
    .at_end  (at_end),
    .valid   (valid),
    .axis    (axis),
    .coord   (coord),
    .last    (last),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predict the point of one index and queue one coordinate per axis
  function automatic void predict_point(input logic [63:0] idx, input logic end_flag);
    int         n, m, total, l, it, t, q, prev, cur, half, rem, top, s;
    int         u[4], v[4], w[4];
    longint     y[4];
    longint     wt;
    logic [63:0] dmask;
    coord_rec_t rec;
    n = int'(dims_reg);
    m = int'(levels_reg);
    if (n < 1) n = 1;
    if (n > DIMS_CAP) n = DIMS_CAP;
    if (m < 2) m = 2;
    if (m > LEVELS_CAP) m = LEVELS_CAP;
    if (n * m > 64) m = 64 / n;
    for (int i = 0; i < 4; i++) y[i] = 0;
    if (n == 1) begin
      // one dimension: y = x - 1/2, scaled by 2^(m+1)
      if (end_flag) y[0] = longint'(1) << m;
      else y[0] = 2 * longint'(idx & ((64'd1 << m) - 64'd1)) - (longint'(1) << m);
    end else begin
      total = n * m;
      dmask = (64'd1 << n) - 64'd1;
      top   = (1 << n) - 1;
      it    = 0;
      for (int i = 0; i < n; i++) w[i] = 1;
      for (int j = 0; j < m; j++) begin
        wt = longint'(1) << (m - 1 - j);
        if (end_flag) s = top;
        else s = int'((idx >> (total - n * (j + 1))) & dmask);
        // node of this digit: direction u, inversion v, swap axis l
        l = 0;
        if (s == 0 || s == top) begin
          l = n - 1;
          for (int i = 0; i < n; i++) begin
            u[i] = -1;
            v[i] = -1;
          end
          if (s == top) begin
            u[0]     = 1;
            v[0]     = 1;
            v[n - 1] = 1;
          end
        end else begin
          half = 1 << n;
          rem  = s;
          prev = -1;
          q    = 1;
          for (int i = 0; i < n; i++) begin
            half = half >> 1;
            if (rem >= half) begin
              if (rem == half && rem != 1) begin
                l = i;
                q = -1;
              end
              rem = rem - half;
              cur = 1;
            end else begin
              cur = -1;
              if (rem == half - 1 && rem != 0) begin
                l = i;
                q = 1;
              end
            end
            u[i] = -prev * cur;
            v[i] = u[i];
            prev = cur;
          end
          v[l]     = v[l] * q;
          v[n - 1] = -v[n - 1];
        end
        // carry the axis permutation forward
        t = u[0]; u[0] = u[it]; u[it] = t;
        t = v[0]; v[0] = v[it]; v[it] = t;
        if (l == 0) l = it;
        else if (l == it) l = 0;
        it = l;
        for (int i = 0; i < n; i++) begin
          u[i] = u[i] * w[i];
          w[i] = -w[i] * v[i];
          y[i] = y[i] + longint'(u[i]) * wt;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      rec.axis  = 2'(i);
      rec.coord = COORD_W'(y[i]);
      rec.last  = (i == n - 1);
      pending_coords.push_back(rec);
    end
  endfunction

  // Result monitor: every strobe is checked against the oldest expectation
  always @(posedge clk) begin
    coord_rec_t exp_rec;
    if (!rst && valid) begin
      coords_seen++;
      if (pending_coords.size() == 0) begin
        $display("%0t: unexpected result axis %0d coord %0d last %0b",
                 $time, axis, coord, last);
        errors++;
      end else begin
        exp_rec = pending_coords.pop_front();
        if (axis !== exp_rec.axis) begin
          $display("%0t: axis mismatch, expected %0d, actual %0d",
                   $time, exp_rec.axis, axis);
          errors++;
        end
        if (coord !== exp_rec.coord) begin
          $display("%0t: coord mismatch on axis %0d, expected %0d, actual %0d",
                   $time, exp_rec.axis, exp_rec.coord, coord);
          errors++;
        end
        if (last !== exp_rec.last) begin
          $display("%0t: last mismatch on axis %0d, expected %0b, actual %0b",
                   $time, exp_rec.axis, exp_rec.last, last);
          errors++;
        end
      end
    end
  end

  // Send one point; start is left high, the next send with an idle gap or a settle lowers it
  task automatic send_point(input logic [63:0] idx, input logic end_flag,
                            input int idle_pct);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 40);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start  <= 1'b1;
    index  <= idx;
    at_end <= end_flag;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_point(idx, end_flag);
    points_sent++;
    if (end_flag) end_points++;
  endtask

  // Stop sending and wait until every expected coordinate has come back
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers; only called while the block is idle
  task automatic configure(input logic [4:0] dims_data, input logic [4:0] levels_data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_DIMS;
    cfg_data <= dims_data;
    @(negedge clk);
    cfg_idx  <= REG_LEVELS;
    cfg_data <= levels_data;
    @(negedge clk);
    cfg_we   <= 1'b0;
    dims_reg   = dims_data[2:0];
    levels_reg = levels_data;
    settings_cnt++;
  endtask

  // Reset values: two dimensions, ten levels
  task automatic test_reset_values();
    send_point(64'd0, 1'b0, 0);
    send_point({64{1'b1}}, 1'b0, 0);
    send_point(64'h0000_0000_0005_5555, 1'b0, 0);
    send_point(64'h1234_5678_9ABC_DEF0, 1'b1, 0);
  endtask

  // One dimension, including dims 0 acting as 1 and unused high bits
  task automatic test_single_axis();
    settle();
    configure(5'd1, 5'd16);
    send_point(64'd0, 1'b0, 0);
    send_point(64'h0000_0000_0000_FFFF, 1'b0, 0);
    send_point(64'hDEAD_BEEF_0000_8000, 1'b0, 0);
    send_point(64'd0, 1'b1, 0);
    settle();
    configure(5'd0, 5'd2);
    send_point(64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 0);
    send_point(64'd3, 1'b1, 0);
  endtask

  // Every digit value for two, three and four dimensions, plus the corners
  task automatic test_digit_nodes();
    settle();
    configure(5'd2, 5'd4);
    send_point(64'hFFFF_FFFF_FFFF_FF1B, 1'b0, 0);
    settle();
    configure(5'd3, 5'd8);
    send_point(64'hA5A5_A5A5_A505_3977, 1'b0, 0);
    send_point(64'd0, 1'b1, 0);
    settle();
    configure(5'd4, 5'd16);
    send_point(64'h0123_4567_89AB_CDEF, 1'b0, 0);
    send_point(64'hFEDC_BA98_7654_3210, 1'b0, 0);
    send_point(64'd0, 1'b0, 0);
    send_point({64{1'b1}}, 1'b0, 0);
    send_point(64'd0, 1'b1, 0);
  endtask

  // Out-of-range register values clamp to the nearest legal setting
  task automatic test_clamped_settings();
    settle();
    configure(5'd7, 5'd31);
    send_point(64'h8000_0000_0000_0001, 1'b0, 0);
    send_point(64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 0);
    settle();
    configure(5'd5, 5'd1);
    send_point(64'hFFFF_FFFF_FFFF_FF96, 1'b0, 0);
    settle();
    configure(5'b11100, 5'd17);
    send_point(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 0);
    settle();
    configure(5'b11011, 5'd0);
    send_point(64'h0000_0000_0000_0027, 1'b0, 0);
  endtask

  // Random points in blocks, a fresh register setting per block
  task automatic test_random_points(input int idle_pct);
    logic [63:0] idx;
    logic        end_flag;
    logic [4:0]  dims_data;
    logic [4:0]  levels_data;
    int          sel;
    for (int b = 0; b < RAND_BLOCKS; b++) begin
      settle();
      dims_data   = 5'($urandom_range(0, 31));
      levels_data = 5'($urandom_range(0, 31));
      if ($urandom_range(3) != 0) dims_data[2:0] = 3'($urandom_range(1, 4));
      if ($urandom_range(3) != 0) levels_data = 5'($urandom_range(2, 16));
      // make sure the widest and the narrowest settings show up
      if (b == 0) begin
        dims_data   = 5'd4;
        levels_data = 5'd16;
      end else if (b == 1) begin
        dims_data   = 5'd1;
        levels_data = 5'd2;
      end
      configure(dims_data, levels_data);
      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        sel = $urandom_range(15);
        if (sel == 0) idx = '0;
        else if (sel == 1) idx = '1;
        else idx = {32'($urandom), 32'($urandom)};
        end_flag = ($urandom_range(9) == 0);
        send_point(idx, end_flag, idle_pct);
      end
    end
  endtask

  // Timeout guard
  initial begin
    #5_000_000;
    $display("Timeout with %0d coordinates still expected", pending_coords.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Main sequence
  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    index      = '0;
    at_end     = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = REG_DIMS;
    cfg_data   = '0;
    dims_reg   = 3'd2;
    levels_reg = 5'd10;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_single_axis();
    test_digit_nodes();
    test_clamped_settings();
    // receiver stalls do not apply: results cannot be held off
    test_random_points(0);
    test_random_points(56);
    test_random_points(18);
    settle();

    $display("Ran %0d points (%0d at the curve end) over %0d register settings,",
             points_sent, end_points, settings_cnt);
    $display("dims 1..4 with clamps and levels 2..16 with clamps; %0d coordinates checked.",
             coords_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
